// ===== hdl/swtp_pkg.sv =====
// Shared constants, codes and sequencer states for the split window trend projection.
// No dependencies; imported by the top level and the testbench.
package swtp_pkg;

  localparam int unsigned HISTORY_DEPTH = 1024;
  localparam int unsigned AW    = $clog2(HISTORY_DEPTH);      // ring address
  localparam int unsigned CW    = $clog2(HISTORY_DEPTH + 1);  // sample count
  localparam int unsigned SPANW = 16;                         // (lag+1)*future
  localparam int unsigned CMPW  = (SPANW > CW) ? SPANW : CW;
  localparam int unsigned SUMW  = 32 + AW;                    // window sum
  localparam int unsigned MW    = 34;                         // window mean
  localparam int unsigned RW    = MW + 2;                     // signed raw result
  localparam int unsigned DCW   = $clog2(SUMW + 1);           // divider step count

  localparam logic [31:0] FLOOR_Q16 = 32'd66;

  localparam logic       CMD_APPEND = 1'b0;
  localparam logic       CMD_QUERY  = 1'b1;

  localparam logic [1:0] TOOL_COUNTER = 2'd0;
  localparam logic [1:0] TOOL_MEANREV = 2'd1;
  localparam logic [1:0] TOOL_TREND   = 2'd2;

  typedef enum logic [1:0] {
    TAG_OLD,
    TAG_NEW,
    TAG_LAST
  } rd_tag_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPAN,
    S_PAST,
    S_ADDR,
    S_WALK,
    S_DRAIN,
    S_LOAD0,
    S_DIV0,
    S_LOAD1,
    S_DIV1,
    S_CALC,
    S_SAT
  } state_e;

endpackage

// ===== hdl/swtp_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module swtp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/split_window_trend_projection.sv =====
// Split window trend projection: appends are taken in the idle state; a query
// walks its window (past <= depth-1) one read a cycle, then runs the bit-serial
// divider twice (skipped when half is zero) and saturates; the next request can
// be taken from the cycle in which the result becomes valid.
// A waiting result does not block appends; a later query stalls before output.
// Async reset clears ring pointer, sample count and handshakes; RAM is not cleared.
module split_window_trend_projection
  import swtp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // [31:0] sample, [37:32] lag, [47:38] future
  input  logic [2:0]  s_axis_tuser_i,   // [0] command, [2:1] tool
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] projection
  output logic        m_axis_tuser_o    // [0] floor_applied
);

  state_e          state_q, state_d;
  logic [AW-1:0]   wp_q, wp_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [1:0]      tool_q, tool_d;
  logic [5:0]      lag_q, lag_d;
  logic [9:0]      future_q, future_d;
  logic [SPANW-1:0] span_q, span_d;
  logic [AW-1:0]   past_q, past_d;
  logic [AW-1:0]   half_q, half_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [AW-1:0]   iss_q, iss_d;
  logic            rd_v_q, rd_v_d;
  rd_tag_e         rd_tag_q, rd_tag_d;
  logic [SUMW-1:0] sum0_q, sum0_d;
  logic [SUMW-1:0] sum1_q, sum1_d;
  logic [31:0]     latest_q, latest_d;
  logic [SUMW-1:0] quo_q, quo_d;
  logic [AW-1:0]   rem_q, rem_d;
  logic [DCW-1:0]  dcnt_q, dcnt_d;
  logic [MW-1:0]   m0_q, m0_d;
  logic [MW-1:0]   m1_q, m1_d;
  logic [RW-1:0]   raw_q, raw_d;
  logic            out_v_q, out_v_d;
  logic [31:0]     proj_q, proj_d;
  logic            fl_q, fl_d;

  // RAM ports
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [31:0]     ram_rdata;

  // shared divider step: one quotient bit per cycle
  logic [AW:0]     div_trial;
  logic            div_ge;
  logic [AW-1:0]   div_rem;
  logic [SUMW-1:0] div_quo;

  // query arithmetic helpers
  logic [CMPW-1:0] t_ext, span_ext, past_sel;
  logic [AW:0]     start_tmp;
  logic [AW-1:0]   old_len;
  logic [RW-1:0]   lat_s, m0_s, m1_s, diff_s, msum_s;

  swtp_ram #(
    .WIDTH (32),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (s_axis_tdata_i[31:0]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign div_trial = {rem_q, quo_q[SUMW-1]};
  assign div_ge    = div_trial >= {1'b0, half_q};
  assign div_rem   = div_ge ? AW'(div_trial - {1'b0, half_q}) : div_trial[AW-1:0];
  assign div_quo   = {quo_q[SUMW-2:0], div_ge};

  assign t_ext     = CMPW'(cnt_q - CW'(1));
  assign span_ext  = CMPW'(span_q);
  assign past_sel  = (span_ext < t_ext) ? span_ext : t_ext;
  assign start_tmp = {1'b0, wp_q} + (AW+1)'(HISTORY_DEPTH - 1) - {1'b0, past_q};
  assign old_len   = past_q - half_q;

  assign lat_s  = {{(RW-32){1'b0}}, latest_q};
  assign m0_s   = {{(RW-MW){1'b0}}, m0_q};
  assign m1_s   = {{(RW-MW){1'b0}}, m1_q};
  assign diff_s = m1_s - m0_s;
  assign msum_s = m1_s + m0_s;

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    cnt_d    = cnt_q;
    tool_d   = tool_q;
    lag_d    = lag_q;
    future_d = future_q;
    span_d   = span_q;
    past_d   = past_q;
    half_d   = half_q;
    addr_d   = addr_q;
    iss_d    = iss_q;
    rd_v_d   = 1'b0;
    rd_tag_d = rd_tag_q;
    sum0_d   = sum0_q;
    sum1_d   = sum1_q;
    latest_d = latest_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    dcnt_d   = dcnt_q;
    m0_d     = m0_q;
    m1_d     = m1_q;
    raw_d    = raw_q;
    out_v_d  = out_v_q;
    proj_d   = proj_q;
    fl_d     = fl_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_raddr = addr_q;
    s_axis_tready_o = 1'b0;

    // read data lands in the cycle after the address went out
    if (rd_v_q) begin
      case (rd_tag_q)
        TAG_OLD:  sum0_d   = sum0_q + SUMW'(ram_rdata);
        TAG_NEW:  sum1_d   = sum1_q + SUMW'(ram_rdata);
        TAG_LAST: latest_d = ram_rdata;
        default:  latest_d = latest_q;
      endcase
    end

    // output register drains on its own, whatever the sequencer does
    if (out_v_q && m_axis_tready_i) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i[0] == CMD_APPEND) begin
            ram_we = 1'b1;
            wp_d   = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
            if (cnt_q < CW'(HISTORY_DEPTH)) begin
              cnt_d = cnt_q + CW'(1);
            end
          end else begin
            tool_d   = s_axis_tuser_i[2:1];
            lag_d    = s_axis_tdata_i[37:32];
            future_d = s_axis_tdata_i[47:38];
            state_d  = S_SPAN;
          end
        end
      end
      S_SPAN: begin
        span_d  = SPANW'({1'b0, lag_q} + 7'd1) * SPANW'(future_q);
        state_d = S_PAST;
      end
      S_PAST: begin
        past_d   = (cnt_q == '0) ? '0 : past_sel[AW-1:0];
        half_d   = past_d >> 1;
        latest_d = '0;
        state_d  = S_ADDR;
      end
      S_ADDR: begin
        // oldest window sample sits past+1 slots behind the write pointer
        addr_d  = (start_tmp >= (AW+1)'(HISTORY_DEPTH)) ?
                  AW'(start_tmp - (AW+1)'(HISTORY_DEPTH)) : start_tmp[AW-1:0];
        iss_d   = '0;
        sum0_d  = '0;
        sum1_d  = '0;
        state_d = (cnt_q == '0) ? S_LOAD0 : S_WALK;
      end
      S_WALK: begin
        ram_re = 1'b1;
        rd_v_d = 1'b1;
        if (iss_q < old_len) begin
          rd_tag_d = TAG_OLD;
        end else if (iss_q < past_q) begin
          rd_tag_d = TAG_NEW;
        end else begin
          rd_tag_d = TAG_LAST;
        end
        addr_d = (addr_q == AW'(HISTORY_DEPTH - 1)) ? '0 : addr_q + AW'(1);
        iss_d  = iss_q + AW'(1);
        if (iss_q == past_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_LOAD0;
      end
      S_LOAD0: begin
        if (half_q == '0) begin
          m0_d    = '0;
          m1_d    = '0;
          state_d = S_CALC;
        end else begin
          quo_d   = sum0_q;
          rem_d   = '0;
          dcnt_d  = DCW'(SUMW);
          state_d = S_DIV0;
        end
      end
      S_DIV0: begin
        quo_d  = div_quo;
        rem_d  = div_rem;
        dcnt_d = dcnt_q - DCW'(1);
        if (dcnt_q == DCW'(1)) begin
          m0_d    = div_quo[MW-1:0];
          state_d = S_LOAD1;
        end
      end
      S_LOAD1: begin
        quo_d   = sum1_q;
        rem_d   = '0;
        dcnt_d  = DCW'(SUMW);
        state_d = S_DIV1;
      end
      S_DIV1: begin
        quo_d  = div_quo;
        rem_d  = div_rem;
        dcnt_d = dcnt_q - DCW'(1);
        if (dcnt_q == DCW'(1)) begin
          m1_d    = div_quo[MW-1:0];
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        case (tool_q)
          TOOL_COUNTER: raw_d = lat_s - diff_s;
          TOOL_MEANREV: raw_d = msum_s >> 1;
          TOOL_TREND:   raw_d = lat_s + diff_s;
          default:      raw_d = '0;
        endcase
        state_d = S_SAT;
      end
      S_SAT: begin
        // wait here until the previous result has been taken
        if (!out_v_q || m_axis_tready_i) begin
          if (raw_q[RW-1] || (~|raw_q[RW-2:32] && (raw_q[31:0] < FLOOR_Q16))) begin
            proj_d = FLOOR_Q16;
            fl_d   = 1'b1;
          end else if (|raw_q[RW-2:32]) begin
            proj_d = '1;
            fl_d   = 1'b0;
          end else begin
            proj_d = raw_q[31:0];
            fl_d   = 1'b0;
          end
          out_v_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wp_q    <= '0;
      cnt_q   <= '0;
      rd_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      cnt_q   <= cnt_d;
      rd_v_q  <= rd_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tool_q   <= tool_d;
    lag_q    <= lag_d;
    future_q <= future_d;
    span_q   <= span_d;
    past_q   <= past_d;
    half_q   <= half_d;
    addr_q   <= addr_d;
    iss_q    <= iss_d;
    rd_tag_q <= rd_tag_d;
    sum0_q   <= sum0_d;
    sum1_q   <= sum1_d;
    latest_q <= latest_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    dcnt_q   <= dcnt_d;
    m0_q     <= m0_d;
    m1_q     <= m1_d;
    raw_q    <= raw_d;
    proj_q   <= proj_d;
    fl_q     <= fl_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = proj_q;
  assign m_axis_tuser_o  = fl_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("result changed while waiting");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(HISTORY_DEPTH))
    else $error("sample count above ring depth");

  a_read_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> ($past(state_q) == S_WALK))
    else $error("read data tagged outside window walk");

  a_floor_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == FLOOR_Q16))
    else $error("floor flag without floor value");

endmodule

// ===== tb/tb_split_window_trend_projection.sv =====
// Self-checking testbench for split_window_trend_projection: directed, random
// and output back-pressure tests against an in-bench projection predictor.
// Depends on swtp_pkg and the split_window_trend_projection RTL.
module tb_split_window_trend_projection;
  import swtp_pkg::*;

  localparam logic [1:0]  TOOL_UNUSED  = 2'd3;
  localparam longint      FLOOR_RAW    = 64'd66;
  localparam longint      MAX_Q16      = 64'h0000_0000_FFFF_FFFF;
  localparam int unsigned RANDOM_ITEMS = 515;
  localparam int unsigned LONG_HOLD    = 3000;
  localparam int unsigned TAIL_CYCLES  = 1200;

  typedef struct packed {
    logic [31:0] projection;
    logic        floor_applied;
  } projection_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;   // [31:0] sample, [37:32] lag, [47:38] future
  logic [2:0]  s_axis_tuser_i = '0;   // [0] command, [2:1] tool
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;        // [31:0] projection
  logic        m_axis_tuser_o;        // [0] floor_applied

  split_window_trend_projection dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #4 clk_i = ~clk_i;

  // predictor state: mirror of the price ring
  logic [31:0] price_ring [HISTORY_DEPTH];
  int unsigned ring_wr = 0;
  int unsigned ring_count = 0;

  projection_t expected_projections [$];
  int unsigned mismatch_count = 0;

  // sender burst state
  int unsigned burst_left = 0;

  // receiver stall pattern; hold_seq is bumped by a test to request a long hold
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned rx_mode = 0;
  int unsigned mode_left = 0;

  function automatic logic [31:0] price_at(longint back);
    longint idx;
    idx = (longint'(ring_wr) + longint'(HISTORY_DEPTH) - 1 - back) % longint'(HISTORY_DEPTH);
    return price_ring[idx];
  endfunction

  function automatic projection_t predict_projection(logic [1:0] tool, logic [5:0] lag,
                                                     logic [9:0] future);
    longint t, past, half, span_len, latest, m_old, m_new, raw, sum_old, sum_new;
    projection_t res;
    m_old = 0;
    m_new = 0;
    sum_old = 0;
    sum_new = 0;
    if (ring_count == 0) begin
      t = 0;
      past = 0;
      latest = 0;
    end else begin
      t = longint'(ring_count) - 1;
      span_len = (longint'(lag) + 1) * longint'(future);
      past = (span_len < t) ? span_len : t;
      latest = longint'(price_at(0));
    end
    half = past / 2;
    // older window gets past-half samples but is still divided by half
    if (half != 0) begin
      for (longint i = t - past; i < t - half; i++) sum_old += longint'(price_at(t - i));
      for (longint i = t - half; i < t; i++) sum_new += longint'(price_at(t - i));
      m_old = sum_old / half;
      m_new = sum_new / half;
    end
    case (tool)
      TOOL_COUNTER: raw = latest - (m_new - m_old);
      TOOL_MEANREV: raw = (m_new + m_old) / 2;
      TOOL_TREND:   raw = latest + (m_new - m_old);
      default:      raw = 0;
    endcase
    if (raw < FLOOR_RAW) begin
      res.projection = FLOOR_Q16;
      res.floor_applied = 1'b1;
    end else if (raw > MAX_Q16) begin
      res.projection = 32'hFFFF_FFFF;
      res.floor_applied = 1'b0;
    end else begin
      res.projection = raw[31:0];
      res.floor_applied = 1'b0;
    end
    return res;
  endfunction

  // Offer one request; returns at the edge where it is accepted.
  task automatic offer_request(logic cmd, logic [31:0] price, logic [1:0] tool,
                               logic [5:0] lag, logic [9:0] future);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {future, lag, price};
    s_axis_tuser_i  <= {tool, cmd};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (cmd == CMD_APPEND) begin
      price_ring[ring_wr] = price;
      ring_wr = (ring_wr + 1) % HISTORY_DEPTH;
      if (ring_count < HISTORY_DEPTH) ring_count++;
    end else begin
      expected_projections.insert(expected_projections.size(),
                                  predict_projection(tool, lag, future));
    end
  endtask

  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (expected_projections.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : check_result
    projection_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_projections.size() == 0) begin
        $error("unexpected result: projection %h floor_applied %b",
               m_axis_tdata_o, m_axis_tuser_o);
        mismatch_count++;
      end else begin
        want = expected_projections.pop_front();
        if (m_axis_tdata_o !== want.projection) begin
          $error("projection: expected %h, got %h", want.projection, m_axis_tdata_o);
          mismatch_count++;
        end
        if (m_axis_tuser_o !== want.floor_applied) begin
          $error("floor_applied: expected %b, got %b", want.floor_applied, m_axis_tuser_o);
          mismatch_count++;
        end
      end
    end
  end

  // queries before any sample is stored, every tool code
  task automatic test_empty_history();
    offer_request(CMD_QUERY, 32'h0, TOOL_COUNTER, 6'd0, 10'd0);
    offer_request(CMD_QUERY, 32'hFFFF_FFFF, TOOL_MEANREV, 6'd63, 10'd1023);
    offer_request(CMD_QUERY, 32'h0, TOOL_TREND, 6'd1, 10'd2);
    offer_request(CMD_QUERY, 32'h0, TOOL_UNUSED, 6'd63, 10'd0);
    wait_for_results();
  endtask

  // zero half, saturation, floor, odd split and field extremes on a short history
  task automatic test_short_history();
    offer_request(CMD_APPEND, 32'h0, TOOL_UNUSED, 6'd63, 10'd1023);
    offer_request(CMD_QUERY, 32'h0, TOOL_COUNTER, 6'd0, 10'd5);
    offer_request(CMD_APPEND, 32'hFFFF_FFFF, TOOL_COUNTER, 6'd0, 10'd0);
    offer_request(CMD_QUERY, 32'h0, TOOL_MEANREV, 6'd0, 10'd1);
    offer_request(CMD_APPEND, 32'hFFFF_FFFF, TOOL_TREND, 6'd21, 10'd682);
    offer_request(CMD_QUERY, 32'h0, TOOL_TREND, 6'd63, 10'd1023);
    offer_request(CMD_QUERY, 32'h0, TOOL_COUNTER, 6'd63, 10'd1023);
    offer_request(CMD_QUERY, 32'h0, TOOL_MEANREV, 6'd63, 10'd1023);
    offer_request(CMD_QUERY, 32'h0, TOOL_TREND, 6'd0, 10'd0);
    offer_request(CMD_APPEND, 32'h0001_0000, TOOL_MEANREV, 6'd42, 10'd341);
    // past 3: older window holds two samples over a divisor of one
    offer_request(CMD_QUERY, 32'h0, TOOL_COUNTER, 6'd0, 10'd3);
    offer_request(CMD_QUERY, 32'h0, TOOL_MEANREV, 6'd0, 10'd3);
    offer_request(CMD_QUERY, 32'h0, TOOL_UNUSED, 6'd0, 10'd3);
    wait_for_results();
  endtask

  task automatic test_random_mix();
    int unsigned pick;
    logic [31:0] price;
    logic [1:0] tool;
    logic [5:0] lag;
    logic [9:0] future;
    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 55) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) price = $urandom();
        else if (pick < 8) price = $urandom_range(0, 300);
        else price = 32'hFFFF_FFFF - $urandom_range(0, 1000);
        offer_request(CMD_APPEND, price, 2'($urandom()), 6'($urandom()), 10'($urandom()));
      end else begin
        tool = ($urandom_range(0, 9) == 0) ? TOOL_UNUSED : 2'($urandom_range(0, 2));
        pick = $urandom_range(0, 19);
        // mostly short windows; a few long ones exercise the wide lag and future bits
        if (pick == 0) begin
          lag = 6'($urandom());
          future = 10'($urandom());
        end else if (pick == 1) begin
          lag = 6'($urandom());
          future = 10'($urandom_range(0, 3));
        end else begin
          lag = 6'($urandom_range(0, 3));
          future = 10'($urandom_range(0, 10));
        end
        offer_request(CMD_QUERY, $urandom(), tool, lag, future);
      end
    end
    wait_for_results();
  endtask

  // receiver holds off while requests keep coming, so the input must stall
  task automatic test_output_backpressure();
    hold_seq++;
    repeat (4) begin
      offer_request(CMD_APPEND, $urandom(), TOOL_COUNTER, 6'd0, 10'd0);
      offer_request(CMD_QUERY, 32'h0, 2'($urandom_range(0, 2)), 6'($urandom_range(0, 2)),
                    10'($urandom_range(1, 6)));
    end
    wait_for_results();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_history();
    test_short_history();
    test_random_mix();
    test_output_backpressure();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_projections.size() == 0) begin
      $display("tb_split_window_trend_projection: clean");
    end else begin
      $display("tb_split_window_trend_projection: errors");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb_split_window_trend_projection: errors");
    $finish;
  end

endmodule
